/* rtl/wdg_pkg.sv */
package wdg_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int FUNC_W    = 3;
    localparam int SLOT_W    = 4;
    localparam int OWNER_W   = 16;
    localparam int TICK_W    = 32;
    localparam int TIMEOUT_W = 21;
    localparam int MAX_EXT_W = 31;
    localparam int CULPRIT_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 21'd46080;
    localparam logic [MAX_EXT_W-1:0] MAX_EXT_RESET = 31'd1843200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_MAX_EXT = 1'b1
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_REGISTER  = 3'd0,
        FN_KICK      = 3'd1,
        FN_LONG_KICK = 3'd2,
        FN_STOP      = 3'd3,
        FN_CHECK     = 3'd4,
        FN_TICK      = 3'd5
    } func_t;

    // Request token that walks the slot chain, one cell per cycle.
    typedef struct packed {
        logic                 valid;
        func_t                func;
        logic [SLOT_W-1:0]    slot;
        logic [OWNER_W-1:0]   owner;
        logic [TICK_W-1:0]    deadline;
        logic                 found;
        logic [CULPRIT_W-1:0] culprit;
    } chain_t;

endpackage

/* rtl/multi_task_deadline_watchdog_top.sv */
// Request path: accept in idle, register the clamped extension, launch a token
// that walks the slot chain one cell per cycle, then register the result once
// the result register is free; the block takes one request at a time.
// Reset (rst_n, async, active low): all slots unregistered, tick count zero,
// timeout 46080 ticks, long-kick clamp 1843200 ticks; owner/deadline unset.
module multi_task_deadline_watchdog_top #(
    parameter int SLOTS = wdg_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [wdg_pkg::FUNC_W-1:0]      func,
    input  logic [wdg_pkg::SLOT_W-1:0]      slot,
    input  logic [wdg_pkg::OWNER_W-1:0]     owner_id,
    input  logic [wdg_pkg::TICK_W-1:0]      extension_ticks,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            all_healthy,
    output logic [wdg_pkg::CULPRIT_W-1:0]   culprit,
    output logic                            matched,
    output logic                            bad_slot,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [wdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wdg_pkg::MAX_EXT_W-1:0]   cfg_data
);
    import wdg_pkg::*;

    localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W+1)'(SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_LAUNCH,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    func_t                  func_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [OWNER_W-1:0]     owner_reg;
    logic [TICK_W-1:0]      ext_reg;
    logic [TICK_W-1:0]      ext_sel_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [MAX_EXT_W-1:0]   max_ext_reg;
    chain_t                 launch_reg;
    chain_t                 end_reg;

    logic                   out_valid_reg;
    logic                   all_healthy_reg;
    logic [CULPRIT_W-1:0]   culprit_reg;
    logic                   matched_reg;
    logic                   bad_slot_reg;

    // links[0] is fed by the launcher, links[SLOTS] is the chain tail
    chain_t                 links [SLOTS+1];

    logic [TICK_W-1:0]      timeout_ext;
    logic [TICK_W-1:0]      max_ext;
    logic [TICK_W-1:0]      clamp_lo;
    logic [TICK_W-1:0]      ext_sel;
    logic                   is_kick;
    logic                   result_load;

    assign links[0] = launch_reg;

    // One cell per slot; each holds mode, owner and deadline and registers
    // the token on to its neighbor.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        wdg_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[g]),
            .tick     (tick_reg),
            .link_out (links[g+1])
        );
    end

    // Long-kick clamp: raise to timeout first, then lower to the maximum,
    // so a maximum below the timeout wins.
    always_comb
    begin
        timeout_ext = TICK_W'(timeout_reg);
        max_ext     = TICK_W'(max_ext_reg);
        clamp_lo    = (ext_reg < timeout_ext) ? timeout_ext : ext_reg;
        if (func_reg == FN_LONG_KICK)
        begin
            ext_sel = (clamp_lo > max_ext) ? max_ext : clamp_lo;
        end
        else
        begin
            ext_sel = timeout_ext;
        end
        is_kick = (end_reg.func == FN_KICK) || (end_reg.func == FN_LONG_KICK)
                  || (end_reg.func == FN_STOP);
        // result register is free, or being emptied on this edge
        result_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= FN_REGISTER;
            slot_reg        <= '0;
            owner_reg       <= '0;
            ext_reg         <= '0;
            ext_sel_reg     <= '0;
            tick_reg        <= '0;
            timeout_reg     <= TIMEOUT_RESET;
            max_ext_reg     <= MAX_EXT_RESET;
            launch_reg      <= '0;
            end_reg         <= '0;
            out_valid_reg   <= 1'b0;
            all_healthy_reg <= 1'b0;
            culprit_reg     <= '0;
            matched_reg     <= 1'b0;
            bad_slot_reg    <= 1'b0;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    CFG_MAX_EXT: max_ext_reg <= cfg_data;
                    default:     ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func_t'(func);
                        slot_reg  <= slot;
                        owner_reg <= owner_id;
                        ext_reg   <= extension_ticks;
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                begin
                    ext_sel_reg <= ext_sel;
                    state_reg   <= ST_LAUNCH;
                end
                ST_LAUNCH:
                begin
                    launch_reg.valid    <= 1'b1;
                    launch_reg.func     <= func_reg;
                    launch_reg.slot     <= slot_reg;
                    launch_reg.owner    <= owner_reg;
                    launch_reg.deadline <= tick_reg + ext_sel_reg;
                    launch_reg.found    <= 1'b0;
                    launch_reg.culprit  <= '0;
                    state_reg           <= ST_WALK;
                end
                ST_WALK:
                begin
                    // token enters cell 0 for exactly one cycle
                    launch_reg.valid <= 1'b0;
                    if (links[SLOTS].valid)
                    begin
                        end_reg   <= links[SLOTS];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold here while the previous result is still unread
                    if (result_load)
                    begin
                        all_healthy_reg <= (end_reg.func == FN_CHECK) && !end_reg.found;
                        culprit_reg     <= (end_reg.func == FN_CHECK) ? end_reg.culprit
                                                                      : '0;
                        matched_reg     <= is_kick && end_reg.found;
                        bad_slot_reg    <= (end_reg.func == FN_REGISTER)
                                           && ({1'b0, end_reg.slot} >= SLOT_LIM);
                        if (end_reg.func == FN_TICK)
                        begin
                            tick_reg <= tick_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign all_healthy = all_healthy_reg;
    assign culprit     = culprit_reg;
    assign matched     = matched_reg;
    assign bad_slot    = bad_slot_reg;

    // chain is empty whenever a new request can come in
    a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !links[SLOTS].valid)
        else $error("token at chain tail while idle");

    a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        links[SLOTS].valid |-> (state_reg == ST_WALK))
        else $error("token left chain outside walk state");

    a_healthy_no_culprit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_healthy) |-> (culprit == '0))
        else $error("healthy result names a culprit");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({all_healthy, matched, bad_slot}))
        else $error("result flags from more than one function");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tick_reg) |-> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick count moved by other than one");

endmodule

/* rtl/wdg_cell.sv */
module wdg_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wdg_pkg::chain_t           link_in,
    input  logic [wdg_pkg::TICK_W-1:0] tick,
    output wdg_pkg::chain_t           link_out
);
    import wdg_pkg::*;

    typedef enum logic [1:0] {
        MODE_UNREG   = 2'd0,
        MODE_WATCHED = 2'd1,
        MODE_STOPPED = 2'd2
    } mode_t;

    mode_t                mode_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [TICK_W-1:0]    deadline_reg;
    chain_t               link_reg;
    chain_t               link_next;

    logic [TICK_W-1:0]    age;
    logic                 expired;
    logic                 sel;
    logic                 open;
    logic                 claim;

    always_comb
    begin
        // expired when (now - deadline) mod 2^32 is in the lower half
        age     = tick - deadline_reg;
        expired = !age[TICK_W-1];
        sel     = link_in.valid && (link_in.func == FN_REGISTER)
                  && (link_in.slot == SLOT_W'(IDX));
        open    = link_in.valid && !link_in.found && (mode_reg == MODE_WATCHED);
        unique case (link_in.func)
            FN_KICK, FN_LONG_KICK, FN_STOP:
                claim = open && (owner_reg == link_in.owner);
            FN_CHECK:
                claim = open && expired;
            default:
                claim = 1'b0;
        endcase
        link_next = link_in;
        if (claim)
        begin
            link_next.found = 1'b1;
            if (link_in.func == FN_CHECK)
            begin
                link_next.culprit = CULPRIT_W'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNREG;
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
            if (sel)
            begin
                mode_reg <= MODE_WATCHED;
            end
            else if (claim && (link_in.func == FN_STOP))
            begin
                mode_reg <= MODE_STOPPED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            owner_reg    <= link_in.owner;
            deadline_reg <= link_in.deadline;
        end
        else if (claim && (link_in.func == FN_KICK || link_in.func == FN_LONG_KICK))
        begin
            deadline_reg <= link_in.deadline;
        end
    end

    assign link_out = link_reg;

endmodule

/* dv/watchdog_checker.sv */
module watchdog_checker #(
    parameter int SLOTS = wdg_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [wdg_pkg::FUNC_W-1:0]      func,
    input  logic [wdg_pkg::SLOT_W-1:0]      slot,
    input  logic [wdg_pkg::OWNER_W-1:0]     owner_id,
    input  logic [wdg_pkg::TICK_W-1:0]      extension_ticks,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            all_healthy,
    input  logic [wdg_pkg::CULPRIT_W-1:0]   culprit,
    input  logic                            matched,
    input  logic                            bad_slot,
    input  logic                            cfg_we,
    input  logic [wdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wdg_pkg::MAX_EXT_W-1:0]   cfg_data,
    output int                              failures,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wdg_pkg::*;

    localparam int REPORT_CAP = 40;
    localparam logic [TICK_W-1:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_WATCHED = 2'd1,
        SLOT_STOPPED = 2'd2
    } slot_state_t;

    typedef struct packed {
        logic                 healthy;
        logic [CULPRIT_W-1:0] culprit;
        logic                 matched;
        logic                 bad;
    } verdict_t;

    slot_state_t            slot_state [SLOTS];
    logic [TICK_W-1:0]      slot_due   [SLOTS];
    logic [OWNER_W-1:0]     slot_who   [SLOTS];
    logic [TICK_W-1:0]      tick_now;
    logic [TIMEOUT_W-1:0]   timeout_now;
    logic [MAX_EXT_W-1:0]   ext_cap;
    verdict_t               expected_verdicts [$];
    int                     errors;

    // wrap-safe: due at or before now counts as overdue
    function automatic bit is_overdue(logic [TICK_W-1:0] due);
        logic [TICK_W-1:0] lag;
        lag = tick_now - due;
        return lag < HALF_RANGE;
    endfunction

    function automatic verdict_t compute_verdict(
        logic [FUNC_W-1:0]  code,
        logic [SLOT_W-1:0]  idx,
        logic [OWNER_W-1:0] who,
        logic [TICK_W-1:0]  want
    );
        verdict_t          v;
        int                hit;
        logic [TICK_W-1:0] span;
        v    = '0;
        hit  = -1;
        span = want;
        case (code)
            FN_REGISTER:
                if (idx < SLOTS)
                begin
                    slot_who[idx]   = who;
                    slot_due[idx]   = tick_now + TICK_W'(timeout_now);
                    slot_state[idx] = SLOT_WATCHED;
                end
                else
                begin
                    v.bad = 1'b1;
                end
            FN_KICK, FN_LONG_KICK, FN_STOP:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_state[i] == SLOT_WATCHED && slot_who[i] == who)
                        hit = i;
                if (hit >= 0)
                begin
                    v.matched = 1'b1;
                    if (code == FN_KICK)
                    begin
                        slot_due[hit] = tick_now + TICK_W'(timeout_now);
                    end
                    else if (code == FN_LONG_KICK)
                    begin
                        // raise to timeout first, then cap; cap wins if bounds cross
                        if (span < TICK_W'(timeout_now))
                            span = TICK_W'(timeout_now);
                        if (span > TICK_W'(ext_cap))
                            span = TICK_W'(ext_cap);
                        slot_due[hit] = tick_now + span;
                    end
                    else
                    begin
                        slot_state[hit] = SLOT_STOPPED;
                    end
                end
            end
            FN_CHECK:
            begin
                v.healthy = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                    if (v.healthy && slot_state[i] == SLOT_WATCHED && is_overdue(slot_due[i]))
                    begin
                        v.healthy = 1'b0;
                        v.culprit = CULPRIT_W'(i);
                    end
            end
            FN_TICK:
                tick_now = tick_now + 1'b1;
            default:
                ;
        endcase
        return v;
    endfunction

    task automatic compare_field(string what, logic [CULPRIT_W-1:0] exp_v,
                                 logic [CULPRIT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        verdict_t want_v;
        verdict_t seen_v;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_state[i] = SLOT_FREE;
                slot_due[i]   = '0;
                slot_who[i]   = '0;
            end
            tick_now    = '0;
            timeout_now = TIMEOUT_RESET;
            ext_cap     = MAX_EXT_RESET;
            errors      = 0;
            expected_verdicts.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_TIMEOUT: timeout_now = cfg_data[TIMEOUT_W-1:0];
                    CFG_MAX_EXT: ext_cap     = cfg_data;
                    default:     ;
                endcase
            // retire before predicting: a result never belongs to a request
            // taken on the same edge
            if (out_valid && out_ready)
            begin
                seen_v = '{all_healthy, culprit, matched, bad_slot};
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: result with none expected, expected nothing actual %h",
                                 $time, seen_v);
                end
                else
                begin
                    want_v = expected_verdicts.pop_front();
                    compare_field("all_healthy", CULPRIT_W'(want_v.healthy),
                                  CULPRIT_W'(seen_v.healthy));
                    compare_field("culprit",     want_v.culprit, seen_v.culprit);
                    compare_field("matched",     CULPRIT_W'(want_v.matched),
                                  CULPRIT_W'(seen_v.matched));
                    compare_field("bad_slot",    CULPRIT_W'(want_v.bad),
                                  CULPRIT_W'(seen_v.bad));
                end
            end
            if (in_valid && in_ready)
                expected_verdicts.push_back(
                    compute_verdict(func, slot, owner_id, extension_ticks));
            pending  <= expected_verdicts.size();
            failures <= errors;
        end
    end

endmodule

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wdg_pkg::*;

    // func codes the block has no operation for; it must answer with all zeros
    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

    // Longest correct quiet stretch is the deliberate receiver hold (HOLD_CYCLES)
    // plus a sender gap and one trip through the slot chain; this is well above.
    localparam int STALL_LIMIT = 4000;
    // Receiver hold that backs the block up while requests keep coming.
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 500;
    // Settle time at the end.
    localparam int TAIL_CYCLES = 30;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   in_valid        = 1'b0;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func            = '0;
    logic [SLOT_W-1:0]      slot            = '0;
    logic [OWNER_W-1:0]     owner_id        = '0;
    logic [TICK_W-1:0]      extension_ticks = '0;
    logic                   out_valid;
    logic                   out_ready       = 1'b0;
    logic                   all_healthy;
    logic [CULPRIT_W-1:0]   culprit;
    logic                   matched;
    logic                   bad_slot;
    logic                   cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index       = '0;
    logic [MAX_EXT_W-1:0]   cfg_data        = '0;

    int                     failures;
    int                     pending;
    int                     quiet_cycles    = 0;

    // sender-side bookkeeping
    bit                     calm            = 1'b0;
    logic [TIMEOUT_W-1:0]   cur_timeout     = TIMEOUT_RESET;
    logic [MAX_EXT_W-1:0]   cur_cap         = MAX_EXT_RESET;

    always #10 clk = ~clk;

    multi_task_deadline_watchdog_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .slot            (slot),
        .owner_id        (owner_id),
        .extension_ticks (extension_ticks),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .all_healthy     (all_healthy),
        .culprit         (culprit),
        .matched         (matched),
        .bad_slot        (bad_slot),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    watchdog_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .slot            (slot),
        .owner_id        (owner_id),
        .extension_ticks (extension_ticks),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .all_healthy     (all_healthy),
        .culprit         (culprit),
        .matched         (matched),
        .bad_slot        (bad_slot),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending)
    );

    // Idle length drawn from three ranges: most often the shortest, rarely the longest.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 94)
            return $urandom_range(3, 6);
        else
            return $urandom_range(15, 60);
    endfunction

    // Offer one request and hold it until taken. Returns at the accepting edge,
    // after an optional gap; with no gap, valid simply stays high for the next one.
    task automatic issue(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                         logic [OWNER_W-1:0] o, logic [TICK_W-1:0] e);
        int gap;
        in_valid        <= 1'b1;
        func            <= f;
        slot            <= s;
        owner_id        <= o;
        extension_ticks <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result. The first edge lets
    // the checker's count catch up with the last request taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Both registers in back-to-back write cycles; only called with the block idle.
    task automatic set_limits(logic [TIMEOUT_W-1:0] t, logic [MAX_EXT_W-1:0] m);
        cur_timeout = t;
        cur_cap     = m;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= MAX_EXT_W'(t);
        @(posedge clk);
        cfg_index <= CFG_MAX_EXT;
        cfg_data  <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed traffic from a small set of owners, so that kicks and
    // stops find their slots and ticks push deadlines past due; the rest is noise.
    task automatic random_phase(int count);
        logic [OWNER_W-1:0] owners [4];
        logic [FUNC_W-1:0]  f;
        logic [SLOT_W-1:0]  s;
        logic [OWNER_W-1:0] o;
        logic [TICK_W-1:0]  e;
        int                 r;
        foreach (owners[k])
            owners[k] = OWNER_W'($urandom);
        calm = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            s = SLOT_W'($urandom);
            e = $urandom;
            o = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom)
                                            : owners[$urandom_range(0, 3)];
            if (r < 14)
            begin
                f = FN_REGISTER;
                s = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(8, 15))
                                                : SLOT_W'($urandom_range(0, 7));
            end
            else if (r < 28)
            begin
                f = FN_KICK;
            end
            else if (r < 42)
            begin
                f = FN_LONG_KICK;
                // aim at both clamp edges as well as plain values
                case ($urandom_range(0, 3))
                    0: e = $urandom;
                    1: e = $urandom_range(0, 40);
                    2: e = TICK_W'(cur_timeout) + TICK_W'($urandom_range(0, 2)) - 1'b1;
                    default: e = TICK_W'(cur_cap) + TICK_W'($urandom_range(0, 2)) - 1'b1;
                endcase
            end
            else if (r < 50)
            begin
                f = FN_STOP;
            end
            else if (r < 72)
            begin
                f = FN_CHECK;
            end
            else if (r < 95)
            begin
                f = FN_TICK;
            end
            else
            begin
                f = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
            end
            issue(f, s, o, e);
        end
        calm = 1'b0;
    endtask

    // Result side: random back-pressure in windows that switch between random gaps
    // and always-ready, plus one long hold so requests pile up behind a full block.
    initial
    begin : receiver
        int taken;
        int gap;
        int window;
        bit quiet;
        bit held;
        taken  = 0;
        gap    = 0;
        window = 200;
        quiet  = 1'b0;
        held   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (!held && taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                gap = 0;
            end
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                gap--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap = idle_span();
            end
            window--;
            if (window <= 0)
            begin
                quiet  = ($urandom_range(0, 2) == 0);
                window = $urandom_range(100, 400);
            end
        end
    end

    // Watchdog: a run where nothing moves for too long is hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset limits (timeout 46080, cap 1843200) ---
        issue(FN_REGISTER,  4'd0,  16'h0000, 32'h0000_0000);
        issue(FN_REGISTER,  4'd8,  16'hFFFF, 32'hFFFF_FFFF);   // just past the table
        issue(FN_REGISTER,  4'd15, 16'hFFFF, 32'h0000_0000);   // top slot code
        issue(FN_LONG_KICK, 4'd0,  16'h0000, 32'h0000_0000);   // raised to timeout
        issue(FN_LONG_KICK, 4'd0,  16'h0000, 32'hFFFF_FFFF);   // cut to cap
        issue(FN_KICK,      4'd0,  16'h1234, 32'h0000_0000);   // nobody owns it
        issue(FN_CHECK,     4'd0,  16'h0000, 32'h0000_0000);
        issue(FN_SPARE_A,   4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        issue(FN_SPARE_B,   4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        issue(FN_TICK,      4'd0,  16'h0000, 32'h0000_0000);
        drain();

        // --- directed, short timeout: expiry, re-arm, stop ---
        set_limits(21'd2, 31'd5);
        issue(FN_REGISTER,  4'd7,  16'hFFFF, 32'h0000_0000);
        issue(FN_REGISTER,  4'd3,  16'hA5A5, 32'h0000_0000);
        issue(FN_REGISTER,  4'd3,  16'h5A5A, 32'h0000_0000);   // re-arm, new owner
        issue(FN_TICK,      4'd0,  16'h0000, 32'h0000_0000);
        issue(FN_TICK,      4'd0,  16'h0000, 32'h0000_0000);   // deadline == now
        issue(FN_CHECK,     4'd0,  16'h0000, 32'h0000_0000);   // lowest overdue wins
        issue(FN_STOP,      4'd0,  16'h5A5A, 32'h0000_0000);
        issue(FN_CHECK,     4'd0,  16'h0000, 32'h0000_0000);   // stopped slot skipped
        issue(FN_KICK,      4'd0,  16'hFFFF, 32'h0000_0000);
        issue(FN_CHECK,     4'd0,  16'h0000, 32'h0000_0000);
        issue(FN_REGISTER,  4'd3,  16'h0001, 32'h0000_0000);   // re-arm stopped slot
        issue(FN_STOP,      4'd0,  16'h0000, 32'h0000_0000);
        drain();

        // --- directed, crossed clamp bounds: cap below timeout ---
        set_limits(21'd9, 31'd4);
        issue(FN_LONG_KICK, 4'd0,  16'h0001, 32'd100);
        issue(FN_LONG_KICK, 4'd0,  16'h0001, 32'd2);
        drain();

        // --- random phases over a spread of limits, extremes included ---
        set_limits(21'd1, 31'd1);
        random_phase(250);
        drain();
        set_limits(21'd4, 31'd16);
        random_phase(300);
        drain();
        set_limits(21'd0, 31'd8);             // zero timeout arms already overdue
        random_phase(200);
        drain();
        set_limits(21'd10, 31'd3);
        random_phase(250);
        drain();
        set_limits(21'h1F_FFFF, 31'h7FFF_FFFF);
        random_phase(150);
        drain();
        set_limits(21'd1843200, 31'd1);
        random_phase(150);
        drain();
        set_limits(21'd6, 31'h7FFF_FFFF);
        random_phase(350);
        drain();
        set_limits(21'd3, 31'd40);
        random_phase(350);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/wdg_pkg.sv
rtl/wdg_cell.sv
rtl/multi_task_deadline_watchdog_top.sv
dv/watchdog_checker.sv
dv/testbench.sv
